### rtl/core/msl_pkg.sv
// Shared types, register map and reset values for the motor slew limiter.
package msl_pkg;

  // Input mode codes
  localparam logic [1:0] MODE_DRIVE  = 2'd0;
  localparam logic [1:0] MODE_WEAPON = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_STOP   = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DEADBAND  = 3'd0;
  localparam logic [2:0] REG_MAX_SPEED = 3'd1;
  localparam logic [2:0] REG_RAMP_UP   = 3'd2;
  localparam logic [2:0] REG_RAMP_DOWN = 3'd3;
  localparam logic [2:0] REG_TIMEOUT   = 3'd4;
  localparam logic [2:0] REG_FS_ENABLE = 3'd5;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Reset values
  localparam logic [14:0] DEADBAND_RST  = 15'd50;
  localparam logic [14:0] MAX_SPEED_RST = 15'd1000;
  localparam logic [14:0] RAMP_UP_RST   = 15'd20;
  localparam logic [14:0] RAMP_DOWN_RST = 15'd40;
  localparam logic [15:0] TIMEOUT_RST   = 16'd500;
  localparam logic        FS_ENABLE_RST = 1'b1;

  // Idle counter saturates here
  localparam logic [16:0] IDLE_LIMIT = 17'h10000;

  typedef struct packed {
    logic [14:0] deadband_width;
    logic [14:0] max_speed;
    logic [14:0] ramp_up_step;
    logic [14:0] ramp_down_step;
    logic [15:0] wdog_timeout;
    logic        failsafe_enable;
  } cfg_t;

endpackage

### rtl/core/motor_slew_limiter_with_watchdog_core.sv
// Top level: request register, speed/watchdog state update and result register.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------------
//   in       | in_valid/in_ready   | mode, left/right/weapon target
//   out      | out_valid/out_ready | left/right/weapon speed, fired, active
//   cfg      | psel/penable/pready | paddr, pwdata, prdata (6 registers)
//
// One request per cycle while out_ready is high.
// State (speeds, idle counter, latch) updates as a request leaves the input
// register, so the following request sees it on the next cycle.
// Reset is synchronous; valid flags and state reset, payload registers do not.
// A stalled result holds the output register; the input register keeps
// accepting until it too is full.
module motor_slew_limiter_with_watchdog_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_mode,
  input  logic signed [15:0]         in_left_target,
  input  logic signed [15:0]         in_right_target,
  input  logic signed [15:0]         in_weapon_target,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [15:0]         out_left_spd,
  output logic signed [15:0]         out_right_spd,
  output logic signed [15:0]         out_weapon_spd,
  output logic                       out_failsafe_fired,
  output logic                       out_failsafe_active,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [msl_pkg::ADDR_W-1:0] paddr,
  input  logic [msl_pkg::DATA_W-1:0] pwdata,
  output logic [msl_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  msl_pkg::cfg_t cfg;

  logic               s1_valid_r, s1_valid_nxt;
  logic [1:0]         s1_mode_r;
  logic signed [15:0] s1_left_r, s1_right_r, s1_weapon_r;
  logic               in_fire, s1_adv;

  logic signed [15:0] left_r, right_r, weapon_r;
  logic signed [15:0] left_nxt, right_nxt, weapon_nxt;
  logic [16:0]        idle_r, idle_nxt, idle_inc;
  logic               tripped_r, tripped_nxt;
  logic               fired;
  logic signed [15:0] left_slew, right_slew, weapon_slew;

  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_left_r, out_right_r, out_weapon_r;
  logic               out_fired_r, out_active_r;

  msl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: input register drains into result register
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready     = !s1_valid_r || s1_adv;
  assign in_fire      = in_valid && in_ready;
  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r   <= in_mode;
      s1_left_r   <= in_left_target;
      s1_right_r  <= in_right_target;
      s1_weapon_r <= in_weapon_target;
    end
  end

  // Three slew channels
  msl_slew u_slew_left (
    .now    (left_r),
    .target (s1_left_r),
    .cfg    (cfg),
    .speed  (left_slew)
  );

  msl_slew u_slew_right (
    .now    (right_r),
    .target (s1_right_r),
    .cfg    (cfg),
    .speed  (right_slew)
  );

  msl_slew u_slew_weapon (
    .now    (weapon_r),
    .target (s1_weapon_r),
    .cfg    (cfg),
    .speed  (weapon_slew)
  );

  // Saturating idle count for a tick
  assign idle_inc = (idle_r < msl_pkg::IDLE_LIMIT) ? idle_r + 17'd1 : idle_r;

  // Next state per mode
  always_comb begin
    left_nxt    = left_r;
    right_nxt   = right_r;
    weapon_nxt  = weapon_r;
    idle_nxt    = idle_r;
    tripped_nxt = tripped_r;
    fired       = 1'b0;
    unique case (s1_mode_r)
      msl_pkg::MODE_DRIVE: begin
        left_nxt    = left_slew;
        right_nxt   = right_slew;
        idle_nxt    = '0;
        tripped_nxt = 1'b0;
      end
      msl_pkg::MODE_WEAPON: begin
        weapon_nxt  = weapon_slew;
        idle_nxt    = '0;
        tripped_nxt = 1'b0;
      end
      msl_pkg::MODE_TICK: begin
        idle_nxt = idle_inc;
        if (cfg.failsafe_enable && !tripped_r &&
            (idle_inc > {1'b0, cfg.wdog_timeout})) begin
          left_nxt    = '0;
          right_nxt   = '0;
          weapon_nxt  = '0;
          tripped_nxt = 1'b1;
          fired       = 1'b1;
        end
      end
      msl_pkg::MODE_STOP: begin
        left_nxt   = '0;
        right_nxt  = '0;
        weapon_nxt = '0;
      end
      default: ;
    endcase
  end

  // Motor state, committed as the request moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= '0;
      right_r   <= '0;
      weapon_r  <= '0;
      idle_r    <= '0;
      tripped_r <= 1'b0;
    end else if (s1_adv) begin
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      weapon_r  <= weapon_nxt;
      idle_r    <= idle_nxt;
      tripped_r <= tripped_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_left_r   <= left_nxt;
      out_right_r  <= right_nxt;
      out_weapon_r <= weapon_nxt;
      out_fired_r  <= fired;
      out_active_r <= tripped_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_left_spd        = out_left_r;
  assign out_right_spd       = out_right_r;
  assign out_weapon_spd      = out_weapon_r;
  assign out_failsafe_fired  = out_fired_r;
  assign out_failsafe_active = out_active_r;

  // A fired result always reports the latch set and all speeds stopped
  a_fired_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fired_r) |->
      (out_active_r && out_left_r == 16'sd0 && out_right_r == 16'sd0 &&
       out_weapon_r == 16'sd0))
    else $error("failsafe result without stop");

  // Idle counter never passes its saturation point
  a_idle_sat: assert property (@(posedge clk) disable iff (!rst_n)
    idle_r <= msl_pkg::IDLE_LIMIT)
    else $error("idle counter overflow");

  // A command clears the latch and the idle count
  a_cmd_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_mode_r == msl_pkg::MODE_DRIVE ||
                s1_mode_r == msl_pkg::MODE_WEAPON)) |=>
      (!tripped_r && idle_r == 17'd0))
    else $error("command did not clear watchdog");

  // The latch only rises through a firing tick
  a_trip_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(tripped_r) |-> (out_valid_r && out_fired_r))
    else $error("latch set without firing");

endmodule

### rtl/core/msl_regs.sv
// APB-style configuration register file for the motor slew limiter.
module msl_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [msl_pkg::ADDR_W-1:0] paddr,
  input  logic [msl_pkg::DATA_W-1:0] pwdata,
  output logic [msl_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output msl_pkg::cfg_t              cfg
);

  msl_pkg::cfg_t cfg_r;
  msl_pkg::cfg_t cfg_nxt;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        msl_pkg::REG_DEADBAND:  cfg_nxt.deadband_width  = pwdata[14:0];
        msl_pkg::REG_MAX_SPEED: cfg_nxt.max_speed       = pwdata[14:0];
        msl_pkg::REG_RAMP_UP:   cfg_nxt.ramp_up_step    = pwdata[14:0];
        msl_pkg::REG_RAMP_DOWN: cfg_nxt.ramp_down_step  = pwdata[14:0];
        msl_pkg::REG_TIMEOUT:   cfg_nxt.wdog_timeout    = pwdata[15:0];
        msl_pkg::REG_FS_ENABLE: cfg_nxt.failsafe_enable = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband_width  <= msl_pkg::DEADBAND_RST;
      cfg_r.max_speed       <= msl_pkg::MAX_SPEED_RST;
      cfg_r.ramp_up_step    <= msl_pkg::RAMP_UP_RST;
      cfg_r.ramp_down_step  <= msl_pkg::RAMP_DOWN_RST;
      cfg_r.wdog_timeout    <= msl_pkg::TIMEOUT_RST;
      cfg_r.failsafe_enable <= msl_pkg::FS_ENABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      msl_pkg::REG_DEADBAND:  prdata = {17'd0, cfg_r.deadband_width};
      msl_pkg::REG_MAX_SPEED: prdata = {17'd0, cfg_r.max_speed};
      msl_pkg::REG_RAMP_UP:   prdata = {17'd0, cfg_r.ramp_up_step};
      msl_pkg::REG_RAMP_DOWN: prdata = {17'd0, cfg_r.ramp_down_step};
      msl_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg_r.wdog_timeout};
      msl_pkg::REG_FS_ENABLE: prdata = {31'd0, cfg_r.failsafe_enable};
      default:                prdata = '0;
    endcase
  end

endmodule

### rtl/core/msl_slew.sv
// One speed channel: deadband, symmetric clamp and ramp limit.
module msl_slew (
  input  logic signed [15:0] now,
  input  logic signed [15:0] target,
  input  msl_pkg::cfg_t      cfg,
  output logic signed [15:0] speed
);

  logic signed [17:0] tgt_x;
  logic signed [17:0] mag;
  logic signed [17:0] tgt_db;
  logic signed [17:0] tgt_cl;
  logic signed [17:0] lim;
  logic signed [17:0] now_x;
  logic signed [17:0] delta;
  logic signed [17:0] step;
  logic signed [17:0] delta_cl;
  logic signed [17:0] sum;

  assign tgt_x = {{2{target[15]}}, target};
  assign now_x = {{2{now[15]}}, now};
  assign lim   = {3'd0, cfg.max_speed};

  // Deadband on magnitude, then clamp to +-max_speed
  always_comb begin
    mag    = tgt_x[17] ? -tgt_x : tgt_x;
    tgt_db = (mag < $signed({3'd0, cfg.deadband_width})) ? 18'sd0 : tgt_x;
    if (tgt_db > lim) begin
      tgt_cl = lim;
    end else if (tgt_db < -lim) begin
      tgt_cl = -lim;
    end else begin
      tgt_cl = tgt_db;
    end
  end

  // Ramp limit: up step for positive difference, down step otherwise
  always_comb begin
    delta = tgt_cl - now_x;
    step  = (delta > 18'sd0) ? $signed({3'd0, cfg.ramp_up_step})
                             : $signed({3'd0, cfg.ramp_down_step});
    if (delta > step) begin
      delta_cl = step;
    end else if (delta < -step) begin
      delta_cl = -step;
    end else begin
      delta_cl = delta;
    end
    sum = now_x + delta_cl;
  end

  assign speed = sum[15:0];

endmodule
